[hdl/mpct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_pkg
// Types and constants for the MP configuration table checker and CPU counter.
// ----------------------------------------------------------------------------
package mpct_pkg;

    typedef logic [15:0] pos_t;        // byte offset within the table
    typedef logic [16:0] entry_pos_t;  // entry offset, one bit wider so it never wraps
    typedef logic [11:0] tally_t;      // processor count

    localparam int HEAD_BYTES = 5;

    localparam pos_t       SIG_LEN            = 16'd4;
    localparam pos_t       LEN_HI_POS         = 16'd5;
    localparam pos_t       SUM_HEAD_BYTES     = 16'd6;
    localparam pos_t       FIRST_ENTRY_OFFSET = 16'd44;
    localparam entry_pos_t ENTRY_START_RESET  = 17'd44;
    localparam entry_pos_t PROC_ENTRY_BYTES   = 17'd20;
    localparam entry_pos_t OTHER_ENTRY_BYTES  = 17'd8;
    localparam entry_pos_t PROC_FLAG_DIST     = 17'd17;

    localparam logic [7:0] ENTRY_TYPE_PROC    = 8'h00;
    localparam logic [7:0] ENTRY_TYPE_LAST    = 8'h04;
    localparam logic [7:0] PROC_ENABLED_BIT   = 8'h01;
    localparam tally_t     TALLY_MAX          = 12'hFFF;

    // Signature "PCMP", byte 0 first
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h50;
            2'd1:    val = 8'h43;
            2'd2:    val = 8'h4D;
            default: val = 8'h50;
        endcase
        return val;
    endfunction

endpackage

[hdl/mp_config_table_cpu_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp_config_table_cpu_counter_core
// Checks an MP configuration table streamed one byte per transfer and counts
// the enabled processor entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one table byte per transfer, with
//   start_of_table set on byte 0. A start abandons any table in progress.
//   Bytes with no table open are dropped.
//   Output channel (out_valid / out_stall): one transfer per table, at byte
//   max(length-1, 5): table_valid, enabled_cpu_count, reported_cpus.
//   Bytes after that byte are dropped until the next start.
// Timing:
//   A byte goes into an input register, then through one pass of update
//   logic into the result register, which drives out_valid. One byte is
//   taken every cycle while in_stall is low.
//   in_stall rises only while the input register holds a final byte and the
//   result register is full and stalled; other bytes keep flowing.
// Reset:
//   rst_n clears both registers and the table state; no table is open.
// ----------------------------------------------------------------------------
module mp_config_table_cpu_counter_core
    import mpct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  table_byte,
    input  logic        start_of_table,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        table_valid,
    output logic [11:0] enabled_cpu_count,
    output logic [11:0] reported_cpus
);

    // input register
    logic       st_valid_reg;
    logic [7:0] st_byte_reg;
    logic       st_start_reg;

    // table state
    logic       active_reg,  active_next;
    pos_t       pos_reg,     pos_next;
    pos_t       len_reg,     len_next;
    logic [7:0] sum_reg,     sum_next;
    logic       sig_reg,     sig_next;
    entry_pos_t es_reg,      es_next;
    logic       proc_reg,    proc_next;
    logic       stop_reg,    stop_next;
    tally_t     tally_reg,   tally_next;
    logic [7:0] hb_reg [HEAD_BYTES];

    // result register
    logic       out_valid_reg;
    logic       valid_reg,   valid_next;
    tally_t     count_reg;
    tally_t     det_reg,     det_next;

    logic       act;
    logic       produce;
    logic       advance;
    pos_t       p;
    pos_t       last;
    logic [7:0] b;
    logic [7:0] head_sum;

    assign b = st_byte_reg;
    assign act = st_valid_reg && (st_start_reg || active_reg);

    always_comb
    begin
        logic       cur_sig;
        logic [7:0] cur_sum;
        pos_t       cur_len;
        entry_pos_t cur_es;
        logic       cur_proc;
        logic       cur_stop;
        tally_t     cur_tally;

        // a start byte sees a freshly cleared table
        p         = st_start_reg ? '0 : pos_reg;
        cur_sig   = st_start_reg ? 1'b1 : sig_reg;
        cur_sum   = st_start_reg ? '0 : sum_reg;
        cur_len   = st_start_reg ? '0 : len_reg;
        cur_es    = st_start_reg ? ENTRY_START_RESET : es_reg;
        cur_proc  = st_start_reg ? 1'b0 : proc_reg;
        cur_stop  = st_start_reg ? 1'b0 : stop_reg;
        cur_tally = st_start_reg ? '0 : tally_reg;

        sig_next = cur_sig;
        if (p < SIG_LEN && b != sig_byte(p[1:0]))
            sig_next = 1'b0;

        // header sum once the length is known; it covers at most six bytes
        len_next = cur_len;
        head_sum = '0;
        if (p == LEN_HI_POS)
            len_next = {b, hb_reg[4]};
        for (int i = 0; i < HEAD_BYTES; i++)
        begin
            if (16'(i) < len_next)
                head_sum = head_sum + hb_reg[i];
        end
        if (len_next > LEN_HI_POS)
            head_sum = head_sum + b;

        if (p == LEN_HI_POS)
            sum_next = head_sum;
        else if (p > LEN_HI_POS && p < cur_len)
            sum_next = cur_sum + b;
        else
            sum_next = cur_sum;

        // entry walk
        es_next    = cur_es;
        proc_next  = cur_proc;
        stop_next  = cur_stop;
        tally_next = cur_tally;
        if (p >= FIRST_ENTRY_OFFSET && p < cur_len && !cur_stop)
        begin
            if ({1'b0, p} == cur_es)
            begin
                if (b == ENTRY_TYPE_PROC)
                begin
                    proc_next = 1'b1;
                    es_next   = cur_es + PROC_ENTRY_BYTES;
                end
                else if (b <= ENTRY_TYPE_LAST)
                begin
                    proc_next = 1'b0;
                    es_next   = cur_es + OTHER_ENTRY_BYTES;
                end
                else
                begin
                    stop_next = 1'b1;
                end
            end
            else if (cur_proc && ({1'b0, p} + PROC_FLAG_DIST) == cur_es)
            begin
                if ((b & PROC_ENABLED_BIT) != 8'h00 && cur_tally < TALLY_MAX)
                    tally_next = cur_tally + 12'd1;
            end
        end

        last    = (len_next > SUM_HEAD_BYTES) ? len_next - 16'd1 : LEN_HI_POS;
        produce = act && p >= LEN_HI_POS && p == last;

        active_next = !produce;
        pos_next    = p + 16'd1;

        valid_next = sig_next && sum_next == 8'h00;
        det_next   = (valid_next && tally_next != '0) ? tally_next : 12'd1;
    end

    // hold a final byte while the result register is full and stalled
    assign advance  = !produce || !out_valid_reg || !out_stall;
    assign in_stall = st_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
            st_byte_reg  <= '0;
            st_start_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            st_valid_reg <= in_valid;
            st_byte_reg  <= table_byte;
            st_start_reg <= start_of_table;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            len_reg    <= '0;
            sum_reg    <= '0;
            sig_reg    <= 1'b1;
            es_reg     <= ENTRY_START_RESET;
            proc_reg   <= 1'b0;
            stop_reg   <= 1'b0;
            tally_reg  <= '0;
            for (int i = 0; i < HEAD_BYTES; i++)
                hb_reg[i] <= '0;
        end
        else if (act && advance)
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            sig_reg    <= sig_next;
            es_reg     <= es_next;
            proc_reg   <= proc_next;
            stop_reg   <= stop_next;
            tally_reg  <= tally_next;
            if (p < 16'(HEAD_BYTES))
                hb_reg[p[2:0]] <= b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
            count_reg     <= '0;
            det_reg       <= 12'd1;
        end
        else if (produce && advance)
        begin
            out_valid_reg <= 1'b1;
            valid_reg     <= valid_next;
            count_reg     <= tally_next;
            det_reg       <= det_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign table_valid       = valid_reg;
    assign enabled_cpu_count = count_reg;
    assign reported_cpus     = det_reg;

`ifndef SYNTHESIS
    a_det_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> reported_cpus != 12'd0)
        else $error("reported_cpus is zero");

    a_invalid_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !table_valid |-> reported_cpus == 12'd1)
        else $error("invalid table must report one cpu");

    a_stall_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> produce && out_valid && out_stall)
        else $error("input stalled without a pending result");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        produce && advance |=> out_valid && enabled_cpu_count == $past(tally_next))
        else $error("result not loaded");
`endif

endmodule

[verif/tb_mp_config_table_cpu_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mp_config_table_cpu_counter_core
// Streams MP configuration tables byte by byte into the checker, with random
// gaps on the input and random stalls on the output, and checks every table
// report against a cycle-free parser model or a directed table's known result.
// Directed tables cover empty, short, corrupted and long tables, each entry
// type, walk stops and restarts. Random tables follow.
// ----------------------------------------------------------------------------
module tb_mp_config_table_cpu_counter_core;
    import mpct_pkg::*;

    localparam int          CYCLE_LIMIT   = 50_000;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          RANDOM_BYTES  = 550;
    localparam logic [31:0] PCMP_SIG      = 32'h504D_4350;  // byte 0 in the low bits

    typedef enum logic [1:0] {LAY_RANDOM, LAY_ALL_PROC, LAY_EACH_TYPE, LAY_BAD_FIRST} layout_t;
    typedef enum logic [1:0] {SUM_ZERO, SUM_OFF, SUM_RANDOM} sum_sel_t;

    typedef struct packed {
        logic   ok;
        tally_t count;
        tally_t cpus;
    } table_report_t;

    typedef struct {
        logic          sig_good;
        int            len;
        layout_t       lay;
        sum_sel_t      sum_mode;
        int            abort_len;   // bytes of an abandoned table sent first
        int            noise;       // stray bytes before the table
        int            extras;      // bytes after the final byte
        logic          typed;
        table_report_t known;
    } table_case_t;

    localparam int N_DIRECTED = 17;

    table_case_t directed_cases [N_DIRECTED] = '{
        '{1'b1, 0,     LAY_RANDOM,    SUM_RANDOM, 0,  3, 0, 1'b1, '{1'b1, 12'd0, 12'd1}},
        '{1'b0, 0,     LAY_RANDOM,    SUM_RANDOM, 0,  0, 0, 1'b1, '{1'b0, 12'd0, 12'd1}},
        '{1'b1, 3,     LAY_RANDOM,    SUM_RANDOM, 0,  0, 2, 1'b1, '{1'b0, 12'd0, 12'd1}},
        '{1'b1, 5,     LAY_RANDOM,    SUM_RANDOM, 0,  0, 0, 1'b0, '0},
        '{1'b1, 6,     LAY_RANDOM,    SUM_RANDOM, 0,  0, 0, 1'b0, '0},
        '{1'b1, 7,     LAY_RANDOM,    SUM_ZERO,   0,  0, 0, 1'b1, '{1'b1, 12'd0, 12'd1}},
        '{1'b1, 44,    LAY_RANDOM,    SUM_ZERO,   0,  0, 0, 1'b1, '{1'b1, 12'd0, 12'd1}},
        '{1'b1, 64,    LAY_ALL_PROC,  SUM_ZERO,   0,  0, 0, 1'b1, '{1'b1, 12'd1, 12'd1}},
        '{1'b1, 104,   LAY_ALL_PROC,  SUM_ZERO,   0,  0, 4, 1'b1, '{1'b1, 12'd3, 12'd3}},
        '{1'b1, 104,   LAY_ALL_PROC,  SUM_OFF,    0,  0, 0, 1'b1, '{1'b0, 12'd3, 12'd1}},
        '{1'b0, 104,   LAY_ALL_PROC,  SUM_ZERO,   0,  0, 0, 1'b1, '{1'b0, 12'd3, 12'd1}},
        '{1'b1, 104,   LAY_BAD_FIRST, SUM_ZERO,   0,  0, 0, 1'b1, '{1'b1, 12'd0, 12'd1}},
        '{1'b1, 47,    LAY_ALL_PROC,  SUM_ZERO,   0,  0, 0, 1'b1, '{1'b1, 12'd0, 12'd1}},
        '{1'b1, 48,    LAY_ALL_PROC,  SUM_ZERO,   0,  0, 0, 1'b1, '{1'b1, 12'd1, 12'd1}},
        '{1'b1, 64,    LAY_ALL_PROC,  SUM_ZERO,   30, 0, 5, 1'b1, '{1'b1, 12'd1, 12'd1}},
        '{1'b1, 200,   LAY_EACH_TYPE, SUM_ZERO,   0,  0, 0, 1'b1, '{1'b1, 12'd1, 12'd1}},
        '{1'b1, 300,   LAY_RANDOM,    SUM_ZERO,   0,  0, 0, 1'b0, '0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  table_byte;
    logic        start_of_table;
    logic        out_valid;
    logic        out_stall;
    logic        table_valid;
    logic [11:0] enabled_cpu_count;
    logic [11:0] reported_cpus;

    // Parser model state
    logic       tbl_open;
    pos_t       byte_idx;
    pos_t       tbl_len;
    logic [7:0] byte_sum;
    logic       sig_seen;
    entry_pos_t next_entry;
    logic       in_proc;
    logic       walk_done;
    tally_t     tally;
    logic [7:0] hdr [HEAD_BYTES];

    table_report_t pending_reports [$];
    logic [7:0]    frame [$];

    logic tx_calm;
    logic rx_calm;
    int   hold_reqs;
    int   bad_count;
    int   reports_seen;
    int   cpu_reports;
    int   table_bytes;
    int   tables_sent;
    int   cycle_count;

    mp_config_table_cpu_counter_core u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .table_byte        (table_byte),
        .start_of_table    (start_of_table),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .table_valid       (table_valid),
        .enabled_cpu_count (enabled_cpu_count),
        .reported_cpus     (reported_cpus)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void clear_tracker();
        byte_idx   = '0;
        tbl_len    = '0;
        byte_sum   = 8'h00;
        sig_seen   = 1'b1;
        next_entry = ENTRY_START_RESET;
        in_proc    = 1'b0;
        walk_done  = 1'b0;
        tally      = '0;
        for (int i = 0; i < HEAD_BYTES; i++)
        begin
            hdr[i] = 8'h00;
        end
    endfunction

    // Advance the parser model by one byte; return 1 when it closes a table.
    function automatic logic parse_table_byte(input logic [7:0] data, input logic sof,
                                              output table_report_t rpt);
        pos_t       p;
        pos_t       last;
        logic [7:0] acc;
        int         i;
        rpt = '0;
        if (sof)
        begin
            clear_tracker();
            tbl_open = 1'b1;
        end
        else if (!tbl_open)
        begin
            return 1'b0;
        end
        p = byte_idx;
        if (p < SIG_LEN && data != PCMP_SIG[{p[1:0], 3'b000} +: 8])
            sig_seen = 1'b0;
        if (p < HEAD_BYTES)
            hdr[p[2:0]] = data;

        if (p == LEN_HI_POS)
        begin
            tbl_len = {data, hdr[4]};
            acc = 8'h00;
            for (i = 0; i < 6 && i < int'(tbl_len); i++)
            begin
                acc = acc + ((i < 5) ? hdr[i] : data);
            end
            byte_sum = acc;
        end
        else if (p > LEN_HI_POS && p < tbl_len)
        begin
            byte_sum = byte_sum + data;
        end

        if (p >= FIRST_ENTRY_OFFSET && p < tbl_len && !walk_done)
        begin
            if ({1'b0, p} == next_entry)
            begin
                if (data == ENTRY_TYPE_PROC)
                begin
                    in_proc    = 1'b1;
                    next_entry = next_entry + PROC_ENTRY_BYTES;
                end
                else if (data <= ENTRY_TYPE_LAST)
                begin
                    in_proc    = 1'b0;
                    next_entry = next_entry + OTHER_ENTRY_BYTES;
                end
                else
                begin
                    walk_done = 1'b1;
                end
            end
            else if (in_proc && ({1'b0, p} + PROC_FLAG_DIST) == next_entry)
            begin
                if ((data & PROC_ENABLED_BIT) != 8'h00 && tally != TALLY_MAX)
                    tally = tally + 1'b1;
            end
        end

        last = (tbl_len > 16'd6) ? tbl_len - 1'b1 : LEN_HI_POS;
        if (p >= LEN_HI_POS && p == last)
        begin
            rpt.ok    = sig_seen && byte_sum == 8'h00;
            rpt.count = tally;
            rpt.cpus  = (rpt.ok && tally != '0) ? tally : tally_t'(1);
            tbl_open  = 1'b0;
            return 1'b1;
        end
        byte_idx = p + 1'b1;
        return 1'b0;
    endfunction

    // Lay out one table image in frame: header, entry walk, then checksum fixup.
    task automatic compose_table(input logic sig_good, input int len, input layout_t lay,
                                 input sum_sel_t sum_mode);
        int         n;
        int         p;
        int         i;
        int         idx;
        int         rr;
        logic [7:0] et;
        logic [7:0] acc;
        logic       en;
        frame.delete();
        n = (len > 6) ? len : 6;
        for (i = 0; i < n; i++)
        begin
            frame.push_back(8'($urandom_range(255)));
        end
        for (i = 0; i < 4; i++)
        begin
            frame[i] = PCMP_SIG[8 * i +: 8];
        end
        if (!sig_good)
        begin
            i = $urandom_range(3);
            frame[i] = frame[i] ^ 8'($urandom_range(255, 1));
        end
        frame[4] = len[7:0];
        frame[5] = len[15:8];

        p   = int'(FIRST_ENTRY_OFFSET);
        idx = 0;
        while (p < n)
        begin
            case (lay)
                LAY_ALL_PROC:  et = ENTRY_TYPE_PROC;
                LAY_EACH_TYPE: et = (idx <= int'(ENTRY_TYPE_LAST)) ? 8'(idx) : 8'hFF;
                LAY_BAD_FIRST: et = 8'($urandom_range(255, 5));
                default:
                begin
                    rr = $urandom_range(99);
                    if (rr < 55)
                        et = ENTRY_TYPE_PROC;
                    else if (rr < 95)
                        et = 8'($urandom_range(4, 1));
                    else
                        et = 8'($urandom_range(255, 5));
                end
            endcase
            frame[p] = et;
            if (et == ENTRY_TYPE_PROC)
            begin
                en = (lay != LAY_RANDOM) || ($urandom_range(99) < 70);
                if (p + 3 < n)
                    frame[p + 3] = en ? (frame[p + 3] | PROC_ENABLED_BIT)
                                      : (frame[p + 3] & ~PROC_ENABLED_BIT);
                p += int'(PROC_ENTRY_BYTES);
            end
            else if (et <= ENTRY_TYPE_LAST)
            begin
                p += int'(OTHER_ENTRY_BYTES);
            end
            else
            begin
                break;
            end
            idx++;
        end

        // Byte 6 is free filler: use it to zero the sum, or miss by one.
        if (len >= 7 && sum_mode != SUM_RANDOM)
        begin
            acc = 8'h00;
            for (i = 0; i < len; i++)
            begin
                if (i != 6)
                    acc = acc + frame[i];
            end
            frame[6] = 8'h00 - acc;
            if (sum_mode == SUM_OFF)
                frame[6] = frame[6] + 8'h01;
        end
    endtask

    // One transfer on the input channel; predict on acceptance.
    task automatic send_byte(input logic [7:0] data, input logic sof, input logic typed,
                             input table_report_t known);
        table_report_t rpt;
        @(negedge clk);
        while (!tx_calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        table_byte     <= data;
        start_of_table <= sof;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (sof || tbl_open)
            table_bytes++;
        if (parse_table_byte(data, sof, rpt))
        begin
            if (typed)
                rpt = known;
            pending_reports.push_back(rpt);
        end
    endtask

    task automatic stream_table(input table_case_t tc);
        int i;
        for (i = 0; i < tc.noise; i++)
        begin
            send_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
        end
        if (tc.abort_len > 0)
        begin
            compose_table(1'b1, 1000, LAY_RANDOM, SUM_RANDOM);
            for (i = 0; i < tc.abort_len; i++)
            begin
                send_byte(frame[i], i == 0, 1'b0, '0);
            end
        end
        compose_table(tc.sig_good, tc.len, tc.lay, tc.sum_mode);
        for (i = 0; i < frame.size(); i++)
        begin
            send_byte(frame[i], i == 0, tc.typed, tc.known);
        end
        for (i = 0; i < tc.extras; i++)
        begin
            send_byte(8'($urandom_range(255)), 1'b0, 1'b0, '0);
        end
        tables_sent++;
    endtask

    // Drop valid and hold until every pending report has been taken.
    task automatic drain_reports();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        int served;
        out_stall = 1'b0;
        hold_left = 0;
        served    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != served)
            begin
                served    = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= !rx_calm && ($urandom_range(99) < 20);
            end
        end
    end

    always @(posedge clk)
    begin : report_check
        table_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                if (bad_count < 10)
                    $display("unexpected report: valid=%0b count=%0d cpus=%0d",
                             table_valid, enabled_cpu_count, reported_cpus);
                bad_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                reports_seen++;
                if (enabled_cpu_count != 12'd0)
                    cpu_reports++;
                if (table_valid !== want.ok || enabled_cpu_count !== want.count ||
                    reported_cpus !== want.cpus)
                begin
                    if (bad_count < 10)
                        $display("report %0d: expected valid=%0b count=%0d cpus=%0d, ",
                                 reports_seen, want.ok, want.count, want.cpus,
                                 "got valid=%0b count=%0d cpus=%0d",
                                 table_valid, enabled_cpu_count, reported_cpus);
                    bad_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports pending",
                     cycle_count, pending_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        table_case_t tc;
        int          n;
        int          lr;
        int          base_bytes;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        table_byte     = 8'h00;
        start_of_table = 1'b0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        hold_reqs      = 0;
        bad_count      = 0;
        reports_seen   = 0;
        cpu_reports    = 0;
        table_bytes    = 0;
        tables_sent    = 0;
        cycle_count    = 0;
        tbl_open       = 1'b0;
        clear_tracker();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < N_DIRECTED; n++)
        begin
            stream_table(directed_cases[n]);
        end

        // Hold the output while short tables keep coming, so the input backs up.
        hold_reqs++;
        tx_calm = 1'b1;
        tc = '{1'b1, 0, LAY_RANDOM, SUM_ZERO, 0, 0, 0, 1'b0, '0};
        for (n = 0; n < 6; n++)
        begin
            stream_table(tc);
        end
        tx_calm = 1'b0;
        drain_reports();

        base_bytes = table_bytes;
        n = 0;
        while (table_bytes - base_bytes < RANDOM_BYTES)
        begin
            tx_calm = (n >= 1 && n < 3);
            rx_calm = (n >= 1 && n < 3);
            tc.sig_good = ($urandom_range(99) >= 8);
            lr = $urandom_range(99);
            if (lr < 15)
                tc.len = $urandom_range(43, 0);
            else if (lr < 92)
                tc.len = $urandom_range(160, 44);
            else
                tc.len = $urandom_range(400, 161);
            lr = $urandom_range(99);
            tc.lay = (lr < 70) ? LAY_RANDOM : (lr < 85) ? LAY_ALL_PROC :
                     (lr < 95) ? LAY_EACH_TYPE : LAY_BAD_FIRST;
            lr = $urandom_range(99);
            tc.sum_mode  = (lr < 85) ? SUM_ZERO : (lr < 93) ? SUM_OFF : SUM_RANDOM;
            tc.abort_len = ($urandom_range(99) < 8) ? $urandom_range(60, 1) : 0;
            tc.noise     = ($urandom_range(99) < 10) ? $urandom_range(4, 1) : 0;
            tc.extras    = ($urandom_range(99) < 10) ? $urandom_range(4, 1) : 0;
            tc.typed     = 1'b0;
            tc.known     = '0;
            stream_table(tc);
            if ($urandom_range(99) < 4)
                drain_reports();
            n++;
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        drain_reports();
        repeat (8) @(posedge clk);
        $display("Streamed %0d tables (%0d table bytes, lengths 0 to 400) with gaps and stalls;",
                 tables_sent, table_bytes);
        $display("%0d reports checked, %0d with enabled CPUs.", reports_seen, cpu_reports);
        if (bad_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
hdl/mpct_pkg.sv
hdl/mp_config_table_cpu_counter_core.sv
verif/tb_mp_config_table_cpu_counter_core.sv
